// ----- src/lrnn_pkg.sv -----
// ----------------------------------------------------------------------------
// lrnn_pkg
// shared types and constants of the linear recurrent layer core
// ----------------------------------------------------------------------------
`default_nettype none

package lrnn_pkg;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned FRAC_W  = 12;
  localparam int unsigned UNITS   = 64;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned WADDR_W = 2 * IDX_W;
  localparam int unsigned HADDR_W = IDX_W + 1;
  localparam int unsigned PROD_W  = 2 * DATA_W;
  localparam int unsigned ACC_W   = PROD_W + 8;
  localparam int unsigned RND_W   = ACC_W - FRAC_W;
  localparam int unsigned SUM_W   = RND_W + 1;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  localparam logic [CNT_W-1:0] UNIT_COUNT_RST = CNT_W'(UNITS);
  localparam logic [CNT_W-1:0] UNIT_COUNT_MAX = CNT_W'(UNITS);

  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(2 ** (FRAC_W - 1));
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2 ** (DATA_W - 1) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_FRAME = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic {
    REG_UNIT_COUNT = 1'b0
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_ROUND,
    S_WRITE
  } state_e;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [DATA_W-1:0] wr_data;
    logic              frame_end;
    logic              clear;
  } hs_ctl_t;

  typedef struct packed {
    logic acc_clr;
    logic data_v;
    logic rnd_en;
  } mac_ctl_t;

endpackage

`default_nettype wire

// ----- src/lrnn_if.sv -----
// ----------------------------------------------------------------------------
// lrnn_if
// request and result channels of the linear recurrent layer core
// ----------------------------------------------------------------------------
`default_nettype none

interface lrnn_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         op;
  logic [lrnn_pkg::IDX_W-1:0]         weight_row;
  logic [lrnn_pkg::IDX_W-1:0]         unit_index;
  logic signed [lrnn_pkg::DATA_W-1:0] weight_value;
  logic signed [lrnn_pkg::DATA_W-1:0] sample_value;

  modport source (
    output valid, op, weight_row, unit_index, weight_value, sample_value,
    input  ready
  );
  modport sink (
    input  valid, op, weight_row, unit_index, weight_value, sample_value,
    output ready
  );
endinterface

interface lrnn_out_if;
  logic                               valid;
  logic                               ready;
  logic [lrnn_pkg::IDX_W-1:0]         out_index;
  logic signed [lrnn_pkg::DATA_W-1:0] state_value;
  logic                               frame_last;

  modport source (
    output valid, out_index, state_value, frame_last,
    input  ready
  );
  modport sink (
    input  valid, out_index, state_value, frame_last,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/lrnn_wmem.sv -----
// ----------------------------------------------------------------------------
// lrnn_wmem
// weight store, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lrnn_wmem (
  input  wire logic                               clk_i,
  input  wire logic                               we_i,
  input  wire logic [lrnn_pkg::WADDR_W-1:0]       waddr_i,
  input  wire logic signed [lrnn_pkg::DATA_W-1:0] wdata_i,
  input  wire logic                               re_i,
  input  wire logic [lrnn_pkg::WADDR_W-1:0]       raddr_i,
  output      logic signed [lrnn_pkg::DATA_W-1:0] rdata_o
);

  logic signed [lrnn_pkg::DATA_W-1:0] mem_q [2 ** lrnn_pkg::WADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/lrnn_hstate.sv -----
// ----------------------------------------------------------------------------
// lrnn_hstate
// hidden state, two banks in one memory with per-unit bank and zero flags
// ----------------------------------------------------------------------------
`default_nettype none

module lrnn_hstate (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire lrnn_pkg::hs_ctl_t                  ctl_i,
  output      logic signed [lrnn_pkg::DATA_W-1:0] rdata_o
);

  localparam int unsigned U = lrnn_pkg::UNITS;

  logic [lrnn_pkg::DATA_W-1:0] mem_q [2 ** lrnn_pkg::HADDR_W];
  logic [lrnn_pkg::DATA_W-1:0] rd_q;
  logic                        rd_zero_q;
  logic [U-1:0]                sel_q, sel_d;
  logic [U-1:0]                zero_q, zero_d;
  logic [U-1:0]                dirty_q, dirty_d;
  logic [U-1:0]                wr_mask;

  // old value of a unit sits in bank sel, the new one is written to the other bank
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[{~sel_q[ctl_i.wr_idx], ctl_i.wr_idx}] <= ctl_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_q      <= mem_q[{sel_q[ctl_i.rd_idx], ctl_i.rd_idx}];
      rd_zero_q <= zero_q[ctl_i.rd_idx];
    end
  end

  assign rdata_o = rd_zero_q ? '0 : rd_q;

  always_comb begin
    wr_mask = '0;
    wr_mask[ctl_i.wr_idx] = ctl_i.wr_en;
    sel_d   = sel_q;
    zero_d  = zero_q;
    dirty_d = dirty_q | wr_mask;
    priority if (ctl_i.clear) begin
      zero_d  = '1;
      dirty_d = '0;
    end else if (ctl_i.frame_end) begin
      sel_d   = sel_q ^ dirty_d;
      zero_d  = zero_q & ~dirty_d;
      dirty_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   <= '0;
      zero_q  <= '1;
      dirty_q <= '0;
    end else begin
      sel_q   <= sel_d;
      zero_q  <= zero_d;
      dirty_q <= dirty_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/lrnn_mac.sv -----
// ----------------------------------------------------------------------------
// lrnn_mac
// multiply-accumulate, rounding and saturation of one hidden unit
// ----------------------------------------------------------------------------
`default_nettype none

module lrnn_mac (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire lrnn_pkg::mac_ctl_t                 ctl_i,
  input  wire logic signed [lrnn_pkg::DATA_W-1:0] h_i,
  input  wire logic signed [lrnn_pkg::DATA_W-1:0] w_i,
  input  wire logic signed [lrnn_pkg::DATA_W-1:0] x_i,
  output      logic                               busy_o,
  output      logic signed [lrnn_pkg::DATA_W-1:0] sat_o
);

  localparam int unsigned ACC_W = lrnn_pkg::ACC_W;
  localparam int unsigned SUM_W = lrnn_pkg::SUM_W;

  logic signed [lrnn_pkg::PROD_W-1:0] prod_q;
  logic                               prod_v_q;
  logic signed [ACC_W-1:0]            acc_q;
  logic signed [ACC_W-1:0]            acc_bias;
  logic signed [lrnn_pkg::RND_W-1:0]  rnd_q;
  logic signed [SUM_W-1:0]            sum;

  always_ff @(posedge clk_i) begin
    if (ctl_i.data_v) begin
      prod_q <= h_i * w_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= ctl_i.data_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.acc_clr) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // round half up, then arithmetic shift by the fraction width
  assign acc_bias = acc_q + lrnn_pkg::RND_BIAS;

  always_ff @(posedge clk_i) begin
    if (ctl_i.rnd_en) begin
      rnd_q <= acc_bias[ACC_W-1:lrnn_pkg::FRAC_W];
    end
  end

  assign sum = SUM_W'(rnd_q) + SUM_W'(x_i);

  always_comb begin
    priority if (sum > lrnn_pkg::SAT_HI) begin
      sat_o = lrnn_pkg::DATA_W'(lrnn_pkg::SAT_HI);
    end else if (sum < lrnn_pkg::SAT_LO) begin
      sat_o = lrnn_pkg::DATA_W'(lrnn_pkg::SAT_LO);
    end else begin
      sat_o = sum[lrnn_pkg::DATA_W-1:0];
    end
  end

  assign busy_o = prod_v_q;

endmodule

`default_nettype wire

// ----- src/linear_rnn_forward_step_core.sv -----
// sequence: a frame element steps through run, drain, round and write, then its result is registered;
//   run does one multiply-accumulate a cycle over the weight and hidden state memories, and write
//   waits while the result is not taken; requests are taken only in idle, where load and clear are done
// reset: hidden state reads as zero, unit count is 64, weight store is undefined until loaded
// ----------------------------------------------------------------------------
// linear_rnn_forward_step_core
// forward time step of a linear recurrent layer, sequencer and config port
// ----------------------------------------------------------------------------
`default_nettype none

module linear_rnn_forward_step_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  lrnn_in_if.sink                                in_if,
  lrnn_out_if.source                             out_if,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [lrnn_pkg::APB_AW-1:0]       paddr,
  input  wire logic [lrnn_pkg::APB_DW-1:0]       pwdata,
  output      logic [lrnn_pkg::APB_DW-1:0]       prdata,
  output      logic                              pready
);

  localparam int unsigned IDX_W = lrnn_pkg::IDX_W;
  localparam int unsigned CNT_W = lrnn_pkg::CNT_W;

  lrnn_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0]                   unit_count_q;
  logic [CNT_W-1:0]                   n_eff;
  logic [IDX_W-1:0]                   n_last;
  logic                               cfg_wr;

  logic [IDX_W-1:0]                   k_q, k_d;
  logic [IDX_W-1:0]                   col_q;
  logic signed [lrnn_pkg::DATA_W-1:0] x_q;
  logic                               last_q;
  logic                               rd_v_q;

  logic                               in_acc;
  logic                               frame_ok;
  logic                               out_free;
  logic                               out_valid_q;
  logic [IDX_W-1:0]                   out_index_q;
  logic signed [lrnn_pkg::DATA_W-1:0] out_value_q;
  logic                               out_last_q;

  lrnn_pkg::hs_ctl_t                  hs_ctl;
  lrnn_pkg::mac_ctl_t                 mac_ctl;
  logic                               w_we, w_re;
  logic [lrnn_pkg::WADDR_W-1:0]       w_raddr;
  logic signed [lrnn_pkg::DATA_W-1:0] w_rdata;
  logic signed [lrnn_pkg::DATA_W-1:0] h_rdata;
  logic signed [lrnn_pkg::DATA_W-1:0] sat_value;
  logic                               mac_busy;

  // config register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
                  && (paddr[2] == lrnn_pkg::REG_UNIT_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_count_q <= lrnn_pkg::UNIT_COUNT_RST;
    end else if (cfg_wr) begin
      unit_count_q <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == lrnn_pkg::REG_UNIT_COUNT) begin
      prdata = lrnn_pkg::APB_DW'(unit_count_q);
    end
  end

  always_comb begin
    priority if (unit_count_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (unit_count_q > lrnn_pkg::UNIT_COUNT_MAX) begin
      n_eff = lrnn_pkg::UNIT_COUNT_MAX;
    end else begin
      n_eff = unit_count_q;
    end
  end

  assign n_last   = IDX_W'(n_eff - CNT_W'(1));
  assign in_acc   = in_if.valid && in_if.ready;
  assign frame_ok = (in_if.op == lrnn_pkg::OP_FRAME)
                    && ({1'b0, in_if.unit_index} < n_eff);
  assign out_free = !out_valid_q || out_if.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lrnn_pkg::S_IDLE: begin
        if (in_acc && frame_ok) begin
          state_d = lrnn_pkg::S_RUN;
        end
      end
      lrnn_pkg::S_RUN: begin
        if (k_q == n_last) begin
          state_d = lrnn_pkg::S_DRAIN;
        end
      end
      lrnn_pkg::S_DRAIN: begin
        if (!rd_v_q && !mac_busy) begin
          state_d = lrnn_pkg::S_ROUND;
        end
      end
      lrnn_pkg::S_ROUND: begin
        state_d = lrnn_pkg::S_WRITE;
      end
      lrnn_pkg::S_WRITE: begin
        if (out_free) begin
          state_d = lrnn_pkg::S_IDLE;
        end
      end
      default: state_d = lrnn_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_if.ready       = 1'b0;
    k_d               = k_q;
    w_we              = 1'b0;
    w_re              = 1'b0;
    w_raddr           = {k_q, col_q};
    hs_ctl            = '0;
    hs_ctl.rd_idx     = k_q;
    hs_ctl.wr_idx     = col_q;
    hs_ctl.wr_data    = sat_value;
    mac_ctl           = '0;
    mac_ctl.data_v    = rd_v_q;
    unique case (state_q)
      lrnn_pkg::S_IDLE: begin
        in_if.ready = 1'b1;
        k_d         = '0;
        if (in_acc) begin
          unique case (in_if.op)
            lrnn_pkg::OP_LOAD:  w_we = 1'b1;
            lrnn_pkg::OP_CLEAR: hs_ctl.clear = 1'b1;
            lrnn_pkg::OP_FRAME: mac_ctl.acc_clr = frame_ok;
            default: ;
          endcase
        end
      end
      lrnn_pkg::S_RUN: begin
        w_re         = 1'b1;
        hs_ctl.rd_en = 1'b1;
        k_d          = k_q + IDX_W'(1);
      end
      lrnn_pkg::S_DRAIN: ;
      lrnn_pkg::S_ROUND: begin
        mac_ctl.rnd_en = 1'b1;
      end
      lrnn_pkg::S_WRITE: begin
        hs_ctl.wr_en     = out_free;
        hs_ctl.frame_end = out_free && last_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrnn_pkg::S_IDLE;
      rd_v_q  <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= w_re;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      col_q  <= in_if.unit_index;
      x_q    <= in_if.sample_value;
      last_q <= (in_if.unit_index == n_last);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (hs_ctl.wr_en) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hs_ctl.wr_en) begin
      out_index_q <= col_q;
      out_value_q <= sat_value;
      out_last_q  <= last_q;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.out_index   = out_index_q;
  assign out_if.state_value = out_value_q;
  assign out_if.frame_last  = out_last_q;

  lrnn_wmem u_wmem (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i ({in_if.weight_row, in_if.unit_index}),
    .wdata_i (in_if.weight_value),
    .re_i    (w_re),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  lrnn_hstate u_hstate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (hs_ctl),
    .rdata_o (h_rdata)
  );

  lrnn_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .h_i    (h_rdata),
    .w_i    (w_rdata),
    .x_i    (x_q),
    .busy_o (mac_busy),
    .sat_o  (sat_value)
  );

endmodule

`default_nettype wire
